// ===== rtl/core/tdpt_pkg.sv =====
// Shared constants and types for the trial division prime test.
`timescale 1ns / 1ps
package tdpt_pkg;

	localparam int unsigned VALUE_BITS_DEF = 16;

	// Status of the serial remainder unit, seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} rem_stat_t;

endpackage

// ===== rtl/core/tdpt_if.sv =====
// Valid/ready channel interfaces for the candidate and the result.
`timescale 1ns / 1ps
interface tdpt_in_if #(
	parameter int unsigned VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_out_if #(
	parameter int unsigned VALUE_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic                  is_prime;
	logic [VALUE_BITS-1:0] prime_value;

	modport source (output valid, output is_prime, output prime_value, input ready);
	modport sink   (input valid, input is_prime, input prime_value, output ready);
endinterface

// ===== rtl/core/tdpt_rem_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module tdpt_rem_unit
	import tdpt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output rem_stat_t             stat
);

	localparam int unsigned CNT_W = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] dvd_q;
	logic [VALUE_BITS-1:0] dvs_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS:0]   trial;
	logic [VALUE_BITS:0]   diff;
	logic [VALUE_BITS-1:0] rem_nxt;

	// The next dividend bit drops into the partial remainder each cycle.
	always_comb begin
		trial   = {rem_q, dvd_q[VALUE_BITS-1]};
		diff    = trial - {1'b0, dvs_q};
		rem_nxt = (trial >= {1'b0, dvs_q}) ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(VALUE_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign stat.zero = (rem_nxt == '0);

endmodule

// ===== rtl/core/trial_division_prime_test.sv =====
// Top level of the trial division prime test: sequencer and result register.
`timescale 1ns / 1ps
// One candidate is tested at a time. Candidates below two go straight to the result.
// Otherwise the divisor d runs from 2 while d*d does not exceed the candidate, and each
// divisor is tried by a full pass of the bit-serial remainder unit; a composite stops at
// its smallest factor. The next candidate is taken as soon as the result sits in the
// output register, even if it has not yet been taken.
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tdpt_in_if.sink    query,
	tdpt_out_if.source answer
);

	localparam int unsigned SQ_W = VALUE_BITS + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [VALUE_BITS-1:0] d_q;
	logic [SQ_W-1:0]       sq_q;
	logic                  prime_q;
	logic                  out_valid_q;
	logic                  out_prime_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  sq_over;
	logic                  rem_start;
	logic                  out_load;
	rem_stat_t             rem_stat;

	assign sq_over   = sq_q > {2'b00, n_q};
	assign rem_start = (state_q == ST_CHECK) && !sq_over;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || answer.ready);

	tdpt_rem_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(n_q),
		.divisor (d_q),
		.stat    (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			d_q         <= '0;
			sq_q        <= '0;
			prime_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_prime_q <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (answer.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query.valid) begin
						n_q     <= query.candidate;
						d_q     <= VALUE_BITS'(2);
						sq_q    <= SQ_W'(4);
						prime_q <= 1'b0;
						// Zero and one are not prime and need no divisor.
						state_q <= (query.candidate < VALUE_BITS'(2)) ? ST_DONE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sq_over) begin
						prime_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_stat.done) begin
						if (rem_stat.zero) begin
							state_q <= ST_DONE;
						end else begin
							// (d+1)^2 = d^2 + 2d + 1
							sq_q    <= sq_q + {1'b0, d_q, 1'b0} + SQ_W'(1);
							d_q     <= d_q + VALUE_BITS'(1);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_prime_q <= prime_q;
						out_value_q <= prime_q ? n_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign query.ready        = (state_q == ST_IDLE);
	assign answer.valid       = out_valid_q;
	assign answer.is_prime    = out_prime_q;
	assign answer.prime_value = out_value_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		rem_start |-> !rem_stat.busy)
		else $error("remainder unit restarted while busy");

	a_div_waits_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> rem_stat.busy)
		else $error("waiting on a remainder unit that is idle");

	a_prime_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_prime_q) |-> (out_value_q >= VALUE_BITS'(2)))
		else $error("prime reported below two");

	a_composite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_prime_q) |-> (out_value_q == '0))
		else $error("non-prime result carries a value");

endmodule
